// ===== rtl/core/stack_alu_ops_defines.svh =====
// Assertion macros used by the stack ALU datapath.
`ifndef STACK_ALU_OPS_DEFINES_SVH
`define STACK_ALU_OPS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sao_pkg.sv =====
package sao_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned DEPTH_W = 7;

	localparam logic [OPCODE_W-1:0] OP_NOP = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_SWAP = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_ADD = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_SUB = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DIV = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVER = 2'd3;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_PUSH,
		WR_RES,
		WR_SWAP_TOP,
		WR_SWAP_SEC
	} wr_kind_t;

	typedef struct packed {
		logic latch_in;
		logic mem_rd;
		logic cap_sec;
		logic div_start;
		wr_kind_t wr;
		logic out_load;
		logic [STATUS_W-1:0] status;
	} sao_ctl_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic lt2;
		logic full;
		logic top_zero;
		logic div_done;
	} sao_sts_t;

endpackage

// ===== rtl/core/sao_cmd_if.sv =====
interface sao_cmd_if;
	import sao_pkg::*;

	logic valid;
	logic ready;
	logic [OPCODE_W-1:0] opcode;
	logic signed [WORD_W-1:0] push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink (input valid, input opcode, input push_value, output ready);
endinterface

// ===== rtl/core/sao_rsp_if.sv =====
interface sao_rsp_if;
	import sao_pkg::*;

	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic signed [WORD_W-1:0] top_value;
	logic [DEPTH_W-1:0] stack_depth;

	modport source (output valid, output status, output top_value, output stack_depth,
		input ready);
	modport sink (input valid, input status, input top_value, input stack_depth,
		output ready);
endinterface

// ===== rtl/core/sao_ram.sv =====
module sao_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/core/sao_div.sv =====
module sao_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [sao_pkg::WORD_W-1:0] dividend,
	input logic [sao_pkg::WORD_W-1:0] divisor,
	output logic done,
	output logic [sao_pkg::WORD_W-1:0] quotient
);
	import sao_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] den_q;
	logic neg_q;

	logic [WORD_W-1:0] mag_a;
	logic [WORD_W-1:0] mag_b;
	logic [WORD_W-1:0] rem_sh;
	logic ge;
	logic [WORD_W-1:0] rem_nx;

	assign mag_a = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
	assign rem_sh = {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
	assign ge = (rem_sh >= den_q);
	assign rem_nx = ge ? (rem_sh - den_q) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			den_q <= mag_b;
			neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[WORD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

// ===== rtl/core/sao_ctrl.sv =====
module sao_ctrl (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input sao_pkg::sao_sts_t sts,
	output sao_pkg::sao_ctl_t ctl
);
	import sao_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD,
		S_RD_WAIT,
		S_DIV_START,
		S_DIV_RUN,
		S_WR_RES,
		S_SWAP_A,
		S_SWAP_B,
		S_DONE
	} state_t;

	state_t state_q;
	logic [STATUS_W-1:0] status_q;
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (sts.opcode) inside
						OP_PUSH: begin
							status_q <= sts.full ? ST_OVER : ST_OK;
							state_q <= S_DONE;
						end
						OP_SWAP, OP_ADD, OP_SUB, OP_DIV: begin
							if (sts.lt2) begin
								status_q <= ST_UNDER;
								state_q <= S_DONE;
							end else if (sts.opcode == OP_DIV && sts.top_zero) begin
								status_q <= ST_DIVZERO;
								state_q <= S_DONE;
							end else begin
								status_q <= ST_OK;
								state_q <= S_RD;
							end
						end
						OP_NOP: begin
							status_q <= ST_OK;
							state_q <= S_DONE;
						end
						default: begin
							status_q <= ST_OK;
							state_q <= S_DONE;
						end
					endcase
				end
				S_RD: state_q <= S_RD_WAIT;
				S_RD_WAIT: begin
					if (sts.opcode == OP_SWAP) begin
						state_q <= S_SWAP_A;
					end else if (sts.opcode == OP_DIV) begin
						state_q <= S_DIV_START;
					end else begin
						state_q <= S_WR_RES;
					end
				end
				S_DIV_START: state_q <= S_DIV_RUN;
				S_DIV_RUN: begin
					if (sts.div_done) begin
						state_q <= S_WR_RES;
					end
				end
				S_WR_RES: state_q <= S_DONE;
				S_SWAP_A: state_q <= S_SWAP_B;
				S_SWAP_B: state_q <= S_DONE;
				S_DONE: begin
					if (ctl.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl = '0;
		ctl.wr = WR_NONE;
		ctl.status = status_q;
		unique case (state_q)
			S_IDLE: ctl.latch_in = cmd_valid;
			S_DECODE: begin
				if (sts.opcode == OP_PUSH && !sts.full) begin
					ctl.wr = WR_PUSH;
				end
			end
			S_RD: ctl.mem_rd = 1'b1;
			S_RD_WAIT: ctl.cap_sec = 1'b1;
			S_DIV_START: ctl.div_start = 1'b1;
			S_WR_RES: ctl.wr = WR_RES;
			S_SWAP_A: ctl.wr = WR_SWAP_TOP;
			S_SWAP_B: ctl.wr = WR_SWAP_SEC;
			S_DONE: ctl.out_load = !rsp_valid_q || rsp_ready;
			default: ctl.wr = WR_NONE;
		endcase
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
endmodule

// ===== rtl/core/sao_dpath.sv =====
`include "stack_alu_ops_defines.svh"

module sao_dpath #(
	parameter int unsigned STACK_DEPTH = sao_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input sao_pkg::sao_ctl_t ctl,
	output sao_pkg::sao_sts_t sts,
	input logic [sao_pkg::OPCODE_W-1:0] cmd_opcode,
	input logic signed [sao_pkg::WORD_W-1:0] cmd_push_value,
	output logic [sao_pkg::STATUS_W-1:0] rsp_status,
	output logic signed [sao_pkg::WORD_W-1:0] rsp_top_value,
	output logic [sao_pkg::DEPTH_W-1:0] rsp_stack_depth
);
	import sao_pkg::*;

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);

	logic [OPCODE_W-1:0] op_q;
	logic [WORD_W-1:0] pv_q;
	logic [WORD_W-1:0] top_q;
	logic [WORD_W-1:0] sec_q;
	logic [CW-1:0] count_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [WORD_W-1:0] rsp_top_q;
	logic [DEPTH_W-1:0] rsp_depth_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] div_quo;
	logic div_done;
	logic [WORD_W-1:0] res;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	assign cnt_m1 = count_q - 1'b1;
	assign cnt_m2 = count_q - CW'(2);

	always_comb begin
		case (op_q)
			OP_ADD: res = sec_q + top_q;
			OP_SUB: res = sec_q - top_q;
			default: res = div_quo;
		endcase
	end

	always_comb begin
		mem_we = 1'b1;
		mem_waddr = cnt_m2[AW-1:0];
		mem_wdata = top_q;
		unique case (ctl.wr)
			WR_PUSH: begin
				mem_waddr = count_q[AW-1:0];
				mem_wdata = pv_q;
			end
			WR_RES: mem_wdata = res;
			WR_SWAP_TOP: begin
				mem_waddr = cnt_m1[AW-1:0];
				mem_wdata = sec_q;
			end
			WR_SWAP_SEC: mem_wdata = top_q;
			default: mem_we = 1'b0;
		endcase
	end

	sao_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(ctl.mem_rd),
		.raddr(cnt_m2[AW-1:0]),
		.rdata(rd_data)
	);

	sao_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(ctl.div_start),
		.dividend(sec_q),
		.divisor(top_q),
		.done(div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (ctl.wr == WR_PUSH) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.wr == WR_RES) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			op_q <= cmd_opcode;
			pv_q <= cmd_push_value;
		end
		if (ctl.cap_sec) begin
			sec_q <= rd_data;
		end
		case (ctl.wr)
			WR_PUSH: top_q <= pv_q;
			WR_RES: top_q <= res;
			WR_SWAP_SEC: top_q <= sec_q;
			default: top_q <= top_q;
		endcase
		if (ctl.out_load) begin
			rsp_status_q <= ctl.status;
			rsp_top_q <= (count_q != '0) ? top_q : '0;
			rsp_depth_q <= DEPTH_W'(count_q);
		end
	end

	assign sts.opcode = op_q;
	assign sts.lt2 = (count_q < CW'(2));
	assign sts.full = (count_q == CW'(STACK_DEPTH));
	assign sts.top_zero = (top_q == '0);
	assign sts.div_done = div_done;

	assign rsp_status = rsp_status_q;
	assign rsp_top_value = rsp_top_q;
	assign rsp_stack_depth = rsp_depth_q;

	`SAO_ASSERT_NOW(a_push_not_full, clk, arst_n, ctl.wr == WR_PUSH, !sts.full, "push on full stack")
	`SAO_ASSERT_NOW(a_two_entries, clk, arst_n, ctl.wr == WR_RES || ctl.wr == WR_SWAP_TOP, count_q >= CW'(2), "pop or swap with fewer than two entries")
	`SAO_ASSERT_NOW(a_div_nonzero, clk, arst_n, ctl.div_start, top_q != '0, "division started with zero divisor")
	`SAO_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(STACK_DEPTH), "entry count above stack depth")
	`SAO_ASSERT_NEXT(a_push_count, clk, arst_n, ctl.wr == WR_PUSH, count_q == ($past(count_q) + 1'b1), "push did not grow the stack by one")
endmodule

// ===== rtl/core/stack_alu_ops.sv =====
// Stack-machine execution unit with a bounded stack of signed 32-bit words.
// The cmd channel carries one opcode per transaction: nop, swap, add, sub,
// div or push, with push_value used only by push. The rsp channel returns
// exactly one transaction per command: a status code, the top of the stack
// (zero when empty) and the number of entries after the command.
// Commands are handled one at a time. Nop, push and all error cases go
// from decode straight to the response. Swap, add, sub and div first read
// the second entry; add and sub then write the result, swap writes both
// entries back, and div runs the radix-2 divider, which retires one
// quotient bit per cycle, before it writes the quotient. Stack memory reads
// are registered, so each command that needs the second entry waits for the
// read data. A new command can be accepted once the response is offered.
// The response sits in an output register, so a new command is accepted
// while an earlier response still waits; if the receiver stalls, the next
// command completes and then holds until the pending response is taken.
// An asynchronous reset empties the stack and drops any pending response.
// On an error status the stack is left as it was.
module stack_alu_ops #(
	parameter int unsigned STACK_DEPTH = sao_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	sao_cmd_if.sink cmd,
	sao_rsp_if.source rsp
);
	import sao_pkg::*;

	sao_ctl_t ctl;
	sao_sts_t sts;

	sao_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts(sts),
		.ctl(ctl)
	);

	sao_dpath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.sts(sts),
		.cmd_opcode(cmd.opcode),
		.cmd_push_value(cmd.push_value),
		.rsp_status(rsp.status),
		.rsp_top_value(rsp.top_value),
		.rsp_stack_depth(rsp.stack_depth)
	);
endmodule
